// ===== rtl/servo_packet_framer_crc16_assert.svh =====
// assertion macros shared by the framer checker
`ifndef SERVO_PACKET_FRAMER_CRC16_ASSERT_SVH
`define SERVO_PACKET_FRAMER_CRC16_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SPFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define SPFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

// ===== rtl/spfc_pkg.sv =====
// shared types and constants of the servo packet framer
package spfc_pkg;

  // packet kinds
  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_FRESET = 2'd1,
    FUNC_REBOOT = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic [1:0] RegWrOp = 2'd0;
  localparam logic [1:0] RegFrOp = 2'd1;
  localparam logic [1:0] RegRbOp = 2'd2;

  // register reset values
  localparam logic [7:0] WrOpRst = 8'd3;
  localparam logic [7:0] FrOpRst = 8'd6;
  localparam logic [7:0] RbOpRst = 8'd8;

  localparam int unsigned MaxDataBytesDef = 4;

  // fixed packet bytes
  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam logic [7:0] HdrByte    = 8'hFD;
  localparam logic [7:0] ZeroByte   = 8'h00;
  localparam logic [7:0] FrParmByte = 8'h01;

  // bytes before the crc, and their offset from the length field
  localparam int unsigned PayLenWrite  = 10;
  localparam int unsigned PayLenFreset = 9;
  localparam int unsigned PayLenReboot = 8;
  localparam int unsigned LenOffset    = 5;

  // byte positions inside a packet
  localparam int unsigned PosSync0  = 0;
  localparam int unsigned PosSync1  = 1;
  localparam int unsigned PosHdr    = 2;
  localparam int unsigned PosRsv    = 3;
  localparam int unsigned PosId     = 4;
  localparam int unsigned PosLenLo  = 5;
  localparam int unsigned PosLenHi  = 6;
  localparam int unsigned PosOpcode = 7;
  localparam int unsigned PosParm0  = 8;
  localparam int unsigned PosParm1  = 9;
  localparam int unsigned PosData   = 10;

  localparam logic [15:0] CrcPoly = 16'h8005;

  // control from the sequencer to the crc accumulator
  typedef struct packed {
    logic clr;
    logic en;
  } crc_ctrl_t;

endpackage

// ===== rtl/spfc_crc.sv =====
// crc-16 accumulator, one byte per cycle while enabled, poly 0x8005, msb first
module spfc_crc
  import spfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_ctrl_t   ctrl_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q, crc_d;

  // eight shift steps of the crc for one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // clear on a new command, fold in each payload byte
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.clr) begin
      crc_d = '0;
    end else if (ctrl_i.en) begin
      crc_d = crc_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== rtl/spfc_seq.sv =====
// byte sequencer: walks the packet positions and shifts out data bytes
module spfc_seq
  import spfc_pkg::*;
#(
  parameter int unsigned MAX_DATA_BYTES = MaxDataBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  servo_id_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [2:0]  param_count_i,
  input  logic [31:0] data_i,
  input  logic [7:0]  wr_op_i,
  input  logic [7:0]  fr_op_i,
  input  logic [7:0]  rb_op_i,
  input  logic [15:0] crc_i,
  output logic        busy_o,
  output crc_ctrl_t   crc_ctrl_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o
);

  localparam int unsigned IdxW  = $clog2(PayLenWrite + MAX_DATA_BYTES + 2);
  localparam int unsigned DataW = 8 * MAX_DATA_BYTES;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pay_len_q, pay_len_d;
  func_e           kind_q;
  logic [7:0]      opcode_q, opcode_d;
  logic [7:0]      id_q;
  logic [7:0]      reg_q;
  logic [DataW-1:0] data_q, data_d;

  logic       sending;
  logic       accept;
  logic       is_crc_lo;
  logic       is_last;
  logic       in_payload;
  logic [2:0] cnt_sat;
  logic [7:0] len_byte;

  assign sending    = (state_q == ST_SEND);
  assign is_crc_lo  = sending && (idx_q == pay_len_q);
  assign is_last    = sending && (idx_q == pay_len_q + IdxW'(1));
  assign in_payload = sending && (idx_q < pay_len_q);
  assign busy_o     = sending && !is_last;
  assign accept     = start_i && !busy_o && (func_i != FUNC_NONE);

  // data byte count saturates at the parameter
  assign cnt_sat = (param_count_i > 3'(MAX_DATA_BYTES)) ? 3'(MAX_DATA_BYTES) : param_count_i;

  // payload length and opcode of the incoming command
  always_comb begin
    case (func_i)
      FUNC_WRITE: begin
        pay_len_d = IdxW'(PayLenWrite) + IdxW'(cnt_sat);
        opcode_d  = wr_op_i;
      end
      FUNC_FRESET: begin
        pay_len_d = IdxW'(PayLenFreset);
        opcode_d  = fr_op_i;
      end
      default: begin
        pay_len_d = IdxW'(PayLenReboot);
        opcode_d  = rb_op_i;
      end
    endcase
  end

  // position counter and state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    if (accept) begin
      state_d = ST_SEND;
      idx_d   = '0;
    end else if (is_last) begin
      state_d = ST_IDLE;
    end else if (sending) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  // data shift register, one byte per data position
  always_comb begin
    data_d = data_q;
    if (accept) begin
      data_d = data_i[DataW-1:0];
    end else if (in_payload && (kind_q == FUNC_WRITE) && (idx_q >= IdxW'(PosData))) begin
      data_d = data_q >> 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // command fields, loaded on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pay_len_q <= pay_len_d;
      kind_q    <= func_e'(func_i);
      opcode_q  <= opcode_d;
      id_q      <= servo_id_i;
      reg_q     <= reg_addr_i;
    end
    data_q <= data_d;
  end

  assign len_byte = 8'(pay_len_q) - 8'(LenOffset);

  // byte select by position
  always_comb begin
    if (is_crc_lo) begin
      tx_byte_o = crc_i[7:0];
    end else if (is_last) begin
      tx_byte_o = crc_i[15:8];
    end else begin
      case (idx_q)
        IdxW'(PosSync0),
        IdxW'(PosSync1):  tx_byte_o = SyncByte;
        IdxW'(PosHdr):    tx_byte_o = HdrByte;
        IdxW'(PosRsv):    tx_byte_o = ZeroByte;
        IdxW'(PosId):     tx_byte_o = id_q;
        IdxW'(PosLenLo):  tx_byte_o = len_byte;
        IdxW'(PosLenHi):  tx_byte_o = ZeroByte;
        IdxW'(PosOpcode): tx_byte_o = opcode_q;
        IdxW'(PosParm0):  tx_byte_o = (kind_q == FUNC_WRITE) ? reg_q : FrParmByte;
        IdxW'(PosParm1):  tx_byte_o = ZeroByte;
        default:          tx_byte_o = data_q[7:0];
      endcase
    end
  end

  assign tx_valid_o = sending;
  assign last_o     = is_last;

  assign crc_ctrl_o.clr = accept;
  assign crc_ctrl_o.en  = in_payload;

endmodule

// ===== rtl/servo_packet_framer_crc16.sv =====
// top level: configuration registers, byte sequencer and crc accumulator
//
// One accepted command produces one instruction packet on tx_byte_o, one
// byte per cycle with tx_valid_o high, and the receiver must take every
// byte as it comes. A register write packet is 12 bytes plus the data byte
// count (count saturates at MAX_DATA_BYTES), a factory reset packet is 11
// bytes and a reboot packet 10 bytes. busy drops on the final crc byte, so
// the next command may start in that cycle and its first byte follows
// without a gap. Packet kind 3 is not accepted and sends nothing. Opcode
// registers sit at byte addresses 0, 4 and 8.
module servo_packet_framer_crc16
  import spfc_pkg::*;
#(
  parameter int unsigned MAX_DATA_BYTES = MaxDataBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [7:0]  servo_id_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [2:0]  param_count_i,
  input  logic [31:0] data_i,
  // byte stream
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  wr_op_q, fr_op_q, rb_op_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic [15:0] crc;
  crc_ctrl_t   crc_ctrl;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  // opcode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_op_q <= WrOpRst;
      fr_op_q <= FrOpRst;
      rb_op_q <= RbOpRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegWrOp: wr_op_q <= pwdata[7:0];
        RegFrOp: fr_op_q <= pwdata[7:0];
        RegRbOp: rb_op_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      RegWrOp: prdata = {24'h0, wr_op_q};
      RegFrOp: prdata = {24'h0, fr_op_q};
      RegRbOp: prdata = {24'h0, rb_op_q};
      default: prdata = '0;
    endcase
  end

  spfc_seq #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .func_i        (func_i),
    .servo_id_i    (servo_id_i),
    .reg_addr_i    (reg_addr_i),
    .param_count_i (param_count_i),
    .data_i        (data_i),
    .wr_op_i       (wr_op_q),
    .fr_op_i       (fr_op_q),
    .rb_op_i       (rb_op_q),
    .crc_i         (crc),
    .busy_o        (busy),
    .crc_ctrl_o    (crc_ctrl),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o)
  );

  spfc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (tx_byte_o),
    .crc_o  (crc)
  );

endmodule

// ===== rtl/spfc_checker.sv =====
// port-level checker for the packet framer, bound to the top level
`include "servo_packet_framer_crc16_assert.svh"

module spfc_checker
  import spfc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] func_i,
  input logic       tx_valid_o,
  input logic [7:0] tx_byte_o,
  input logic       last_o
);

  logic go;
  assign go = start && !busy && (func_i != FUNC_NONE);

  // an accepted command opens a packet with a sync byte next cycle
  `SPFC_ASSERT_NEXT(a_pkt_opens, go, busy && tx_valid_o && (tx_byte_o == SyncByte))
  // a packet ends only on a byte that is shown
  `SPFC_ASSERT_NOW(a_last_valid, last_o, tx_valid_o)
  // bytes of one packet follow without a gap
  `SPFC_ASSERT_NEXT(a_no_gap, tx_valid_o && !last_o, tx_valid_o)
  // the block stays busy until the final byte
  `SPFC_ASSERT_NOW(a_busy_mid, tx_valid_o && !last_o, busy)

endmodule

bind servo_packet_framer_crc16 spfc_checker u_spfc_checker (.*);
